FILE: sv/psts_pkg.sv
`timescale 1ns / 1ps

package psts_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned IDX_W   = SIZE_W + 1;
  localparam int unsigned DELTA_W = 32;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned ACC_W   = TOTAL_W + 4;
  localparam int unsigned CMD_W   = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DEPTH);

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUM    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;

  typedef struct packed {
    logic start;
    logic size_write;
    logic clear_start;
    logic clear_step;
    logic skip;
    logic read;
    logic exec;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic active;
    logic skip;
  } dp_status_t;

endpackage

FILE: sv/psts_ctrl.sv
`timescale 1ns / 1ps

module psts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  psts_pkg::dp_status_t status_i,
  output psts_pkg::dp_cmd_t   cmd_o
);
  import psts_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.start = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        if (!status_i.active) begin
          state_d = S_DONE;
        end else if (status_i.skip) begin
          cmd_o.skip = 1'b1;
        end else begin
          cmd_o.read = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_READ;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    // size write restarts the clearing sweep
    if (cfg_valid_i) begin
      cmd_o.size_write  = 1'b1;
      cmd_o.clear_start = 1'b1;
      cmd_o.clear_step  = 1'b0;
      state_d           = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/psts_datapath.sv
`timescale 1ns / 1ps

module psts_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  psts_pkg::dp_cmd_t                    cmd_i,
  output psts_pkg::dp_status_t                 status_o,
  input  logic [psts_pkg::CMD_W-1:0]           op_i,
  input  logic [psts_pkg::SIZE_W-1:0]          index_i,
  input  logic signed [psts_pkg::DELTA_W-1:0]  delta_i,
  input  logic signed [psts_pkg::TOTAL_W-1:0]  target_i,
  input  logic [psts_pkg::SIZE_W-1:0]          size_in_use_i,
  output logic signed [psts_pkg::TOTAL_W-1:0]  prefix_total_o,
  output logic [psts_pkg::SIZE_W-1:0]          position_o
);
  import psts_pkg::*;

  function automatic logic [SIZE_W-1:0] top_pow2(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] p;
    p = '0;
    for (int k = 0; k < SIZE_W; k++) begin
      if (v[k]) begin
        p = SIZE_W'(1) << k;
      end
    end
    return p;
  endfunction

  logic [TOTAL_W-1:0]       mem_q [DEPTH];
  logic [TOTAL_W-1:0]       rdata_q;

  logic [SIZE_W-1:0]        size_q;
  logic [ADDR_W-1:0]        clr_q;
  logic [CMD_W-1:0]         op_q;
  logic [TOTAL_W-1:0]       delta_q;
  logic signed [ACC_W-1:0]  target_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [IDX_W-1:0]         idx_q;
  logic [SIZE_W-1:0]        step_q;
  logic [SIZE_W-1:0]        x_q;
  logic [TOTAL_W-1:0]       total_q;
  logic [SIZE_W-1:0]        pos_q;

  logic [IDX_W-1:0]         size_ext;
  logic [IDX_W-1:0]         lowbit;
  logic [IDX_W-1:0]         sel_pos;
  logic [IDX_W-1:0]         node_ptr;
  logic [ADDR_W-1:0]        node_addr;
  logic signed [ACC_W-1:0]  node_ext;
  logic signed [ACC_W-1:0]  cand;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [TOTAL_W-1:0]       mem_wdata;
  logic [IDX_W-1:0]         idx_start;

  assign size_ext  = {1'b0, size_q};
  assign lowbit    = idx_q & (~idx_q + IDX_W'(1));
  assign sel_pos   = {1'b0, x_q} + {1'b0, step_q};
  assign node_ptr  = ((op_q == CMD_SELECT) ? sel_pos : idx_q) - IDX_W'(1);
  assign node_addr = node_ptr[ADDR_W-1:0];
  assign node_ext  = {{(ACC_W-TOTAL_W){rdata_q[TOTAL_W-1]}}, rdata_q};
  assign cand      = acc_q + node_ext;

  always_comb begin
    status_o            = '0;
    status_o.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
    status_o.skip       = (op_q == CMD_SELECT) && (sel_pos > size_ext);
    unique case (op_q)
      CMD_ADD:    status_o.active = (idx_q != '0) && (idx_q <= size_ext);
      CMD_SUM:    status_o.active = (idx_q != '0);
      CMD_SELECT: status_o.active = (step_q != '0);
      default:    status_o.active = 1'b0;
    endcase
  end

  always_comb begin
    unique case (op_i)
      CMD_ADD:  idx_start = ({1'b0, index_i} < size_ext) ?
                            ({1'b0, index_i} + IDX_W'(1)) : '0;
      CMD_SUM:  idx_start = (index_i > size_q) ? size_ext : {1'b0, index_i};
      default:  idx_start = '0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_addr;
    mem_wdata = rdata_q + delta_q;
    if (cmd_i.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (cmd_i.exec && (op_q == CMD_ADD)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rdata_q <= mem_q[node_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      clr_q  <= '0;
    end else begin
      if (cmd_i.size_write) begin
        size_q <= (size_in_use_i > SIZE_RESET) ? SIZE_RESET : size_in_use_i;
      end
      if (cmd_i.clear_start) begin
        clr_q <= '0;
      end else if (cmd_i.clear_step) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q     <= op_i;
      delta_q  <= {{(TOTAL_W-DELTA_W){delta_i[DELTA_W-1]}}, delta_i};
      target_q <= {{(ACC_W-TOTAL_W){target_i[TOTAL_W-1]}}, target_i};
      acc_q    <= '0;
      x_q      <= '0;
      idx_q    <= idx_start;
      step_q   <= (op_i == CMD_SELECT) ? top_pow2(size_q) : '0;
    end else if (cmd_i.skip) begin
      step_q <= step_q >> 1;
    end else if (cmd_i.exec) begin
      unique case (op_q)
        CMD_ADD: begin
          idx_q <= idx_q + lowbit;
        end
        CMD_SUM: begin
          acc_q <= cand;
          idx_q <= idx_q - lowbit;
        end
        CMD_SELECT: begin
          if (cand <= target_q) begin
            acc_q <= cand;
            x_q   <= sel_pos[SIZE_W-1:0];
          end
          step_q <= step_q >> 1;
        end
        default: begin
          idx_q <= '0;
        end
      endcase
    end
    if (cmd_i.load_result) begin
      total_q <= (op_q == CMD_SUM) ? acc_q[TOTAL_W-1:0] : '0;
      pos_q   <= x_q;
    end
  end

  assign prefix_total_o = total_q;
  assign position_o     = pos_q;

endmodule

FILE: sv/prefix_sum_tree_with_select.sv
`timescale 1ns / 1ps
// Each transaction reads up to 11 tree levels at 1024 entries, plus the select levels
// skipped beyond the size. One transaction is handled at a time: in_ready_o stays low
// until the result is loaded, and a finished result waits while the last one is still
// held for out_ready_i. Reset: size 1024, then a clearing sweep with in_ready_o low;
// every size write starts the same sweep over all 1024 entries.
module prefix_sum_tree_with_select (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [psts_pkg::CMD_W-1:0]           cmd_i,
  input  logic [psts_pkg::SIZE_W-1:0]          index_i,
  input  logic signed [psts_pkg::DELTA_W-1:0]  delta_i,
  input  logic signed [psts_pkg::TOTAL_W-1:0]  target_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [psts_pkg::TOTAL_W-1:0]  prefix_total_o,
  output logic [psts_pkg::SIZE_W-1:0]          position_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [psts_pkg::SIZE_W-1:0]          size_in_use_i
);
  import psts_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  psts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  psts_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .op_i           (cmd_i),
    .index_i        (index_i),
    .delta_i        (delta_i),
    .target_i       (target_i),
    .size_in_use_i  (size_in_use_i),
    .prefix_total_o (prefix_total_o),
    .position_o     (position_o)
  );

endmodule
